@@ src/wwlb_pkg.sv @@
// Shared types, constants and the microcode table of the word-wrap line buffer.
// No dependencies; imported by word_wrap_line_buffer.
`timescale 1ns / 1ps
`default_nettype none

package wwlb_pkg;

    localparam int          LINE_CHARS_DEF = 21;
    localparam int          CHAR_W         = 8;
    localparam logic [7:0]  SPACE_CODE     = 8'd32;
    localparam logic [7:0]  LAST_PRINT     = 8'd127;

    typedef logic [2:0] t_step;

    localparam t_step STEP_IDLE   = 3'd0;
    localparam t_step STEP_STORE  = 3'd1;
    localparam t_step STEP_PREP   = 3'd2;
    localparam t_step STEP_SEARCH = 3'd3;
    localparam t_step STEP_READ0  = 3'd4;
    localparam t_step STEP_EMIT   = 3'd5;
    localparam t_step STEP_LEND   = 3'd6;
    localparam t_step STEP_COPY   = 3'd7;

    // Datapath action selected by a control word.
    typedef enum logic [2:0] {
        OP_IDLE,
        OP_STORE,
        OP_PREP,
        OP_SEARCH,
        OP_READ0,
        OP_EMIT,
        OP_LEND,
        OP_COPY
    } t_op;

    typedef struct packed {
        t_op   op;
        t_step nxt_t;   // next step when the branch condition holds
        t_step nxt_f;   // next step otherwise
    } t_uword;

    // Microcode ROM: one control word per step.
    function automatic t_uword f_ucode(input t_step s);
        t_uword w;
        unique case (s)
            STEP_IDLE:   w = '{OP_IDLE,   STEP_STORE, STEP_IDLE};
            STEP_STORE:  w = '{OP_STORE,  STEP_IDLE,  STEP_PREP};
            STEP_PREP:   w = '{OP_PREP,   STEP_READ0, STEP_SEARCH};
            STEP_SEARCH: w = '{OP_SEARCH, STEP_READ0, STEP_SEARCH};
            STEP_READ0:  w = '{OP_READ0,  STEP_EMIT,  STEP_EMIT};
            STEP_EMIT:   w = '{OP_EMIT,   STEP_LEND,  STEP_EMIT};
            STEP_LEND:   w = '{OP_LEND,   STEP_IDLE,  STEP_COPY};
            STEP_COPY:   w = '{OP_COPY,   STEP_IDLE,  STEP_COPY};
            default:     w = '{OP_IDLE,   STEP_IDLE,  STEP_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic f_printable(input logic [7:0] c);
        return (c >= SPACE_CODE) && (c <= LAST_PRINT);
    endfunction

    function automatic logic f_is_break(input logic [7:0] c);
        return (c <= SPACE_CODE) || (c > LAST_PRINT);
    endfunction

endpackage

`default_nettype wire

@@ src/wwlb_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module wwlb_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 22,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/word_wrap_line_buffer.sv @@
// A printable word that does not fill the line is accepted and stored. A word that closes a
// line passes through accept, store, prepare, a backward search of up to LINE_CHARS-1 slots,
// a read setup, the emit of each slot up to the break, the line-end word and the move of the
// remaining characters to the front; output stalls hold the emit and line-end steps. No new
// word is accepted until the block is back in its idle step. Synchronous reset (i_rst_n low)
// empties the line and output.
`timescale 1ns / 1ps
`default_nettype none

module word_wrap_line_buffer #(
    parameter  int LINE_CHARS = wwlb_pkg::LINE_CHARS_DEF,
    localparam int SLOTS      = LINE_CHARS + 1,
    localparam int AW         = $clog2(SLOTS)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [wwlb_pkg::CHAR_W-1:0] i_char_in,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic      [wwlb_pkg::CHAR_W-1:0] o_glyph,
    output logic                             o_line_end
);

    import wwlb_pkg::*;

    // Slot indexes that the microcode refers to.
    localparam logic [AW-1:0] LAST_SLOT = AW'(LINE_CHARS);
    localparam logic [AW-1:0] PEN_SLOT  = AW'(LINE_CHARS - 1);
    localparam logic [AW-1:0] ONE       = AW'(1);

    // Sequencer: the step counter addresses the control word ROM.
    t_step  r_step, n_step;
    t_uword uw;

    // Datapath registers. r_pos is the fill position, r_idx the working slot index,
    // r_brk the last slot of the line being closed, r_char the word just taken in.
    logic [AW-1:0] r_pos, n_pos;
    logic [AW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_brk, n_brk;
    logic [7:0]    r_char, n_char;

    // Output register; it decouples the emit loop from the downstream ready.
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_glyph, n_glyph;
    logic       r_line_end, n_line_end;

    // Line store port signals.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    logic          cond_true;
    logic          hold;
    logic          out_free;
    logic          in_acc;
    logic [AW-1:0] copy_src;

    wwlb_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (SLOTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign uw          = f_ucode(r_step);
    assign o_in_ready  = (r_step == STEP_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_glyph     = r_glyph;
    assign o_line_end  = r_line_end;

    // Source slot of the next character moved to the front of the line. It never
    // passes the old fill position, so it always fits the slot index width.
    assign copy_src = r_idx + r_brk + AW'(2);

    always_comb begin
        n_pos       = r_pos;
        n_idx       = r_idx;
        n_brk       = r_brk;
        n_char      = r_char;
        n_out_valid = r_out_valid && !i_out_ready;
        n_glyph     = r_glyph;
        n_line_end  = r_line_end;
        ram_we      = 1'b0;
        ram_waddr   = r_pos;
        ram_wdata   = r_char;
        ram_re      = 1'b0;
        ram_raddr   = r_idx;
        cond_true   = 1'b0;
        hold        = 1'b0;

        unique case (uw.op)
            OP_IDLE: begin
                cond_true = in_acc;
                if (in_acc) begin
                    n_char = i_char_in;
                end
            end
            OP_STORE: begin
                // Every word lands at the fill position. A printable word with room
                // left only advances the position.
                ram_we    = 1'b1;
                ram_waddr = r_pos;
                ram_wdata = r_char;
                cond_true = f_printable(r_char) && (r_pos != LAST_SLOT);
                if (cond_true) begin
                    n_pos = r_pos + ONE;
                end
            end
            OP_PREP: begin
                // A break word closes the line at its own slot. When it sits in the
                // last slot the line ends one slot earlier and a space there is dropped.
                // A printable word in the last slot starts the backward search.
                cond_true = f_is_break(r_char);
                if (cond_true) begin
                    if (r_pos == LAST_SLOT) begin
                        n_brk = PEN_SLOT;
                        if (r_char == SPACE_CODE) begin
                            n_pos = r_pos - ONE;
                        end
                    end else begin
                        n_brk = r_pos;
                    end
                end else begin
                    n_idx     = PEN_SLOT;
                    ram_re    = 1'b1;
                    ram_raddr = PEN_SLOT;
                end
            end
            OP_SEARCH: begin
                // Read data is the slot at r_idx. Slot 0 never counts as a break;
                // with no break found the line ends just before the last slot.
                cond_true = f_is_break(ram_rdata) || (r_idx == ONE);
                if (f_is_break(ram_rdata)) begin
                    n_brk = r_idx;
                end else if (r_idx == ONE) begin
                    n_brk = PEN_SLOT;
                end else begin
                    n_idx     = r_idx - ONE;
                    ram_re    = 1'b1;
                    ram_raddr = r_idx - ONE;
                end
            end
            OP_READ0: begin
                cond_true = 1'b1;
                n_idx     = '0;
                ram_re    = 1'b1;
                ram_raddr = '0;
            end
            OP_EMIT: begin
                // One slot per cycle; control codes are skipped, printable words wait
                // for room in the output register. The read data holds while stalled.
                hold      = f_printable(ram_rdata) && !out_free;
                cond_true = (r_idx == r_brk);
                if (!hold) begin
                    if (f_printable(ram_rdata)) begin
                        n_out_valid = 1'b1;
                        n_glyph     = ram_rdata;
                        n_line_end  = 1'b0;
                    end
                    if (!cond_true) begin
                        n_idx     = r_idx + ONE;
                        ram_re    = 1'b1;
                        ram_raddr = r_idx + ONE;
                    end
                end
            end
            OP_LEND: begin
                // The line-end word; the remaining text length becomes the fill position.
                hold      = !out_free;
                cond_true = (r_pos == r_brk);
                if (!hold) begin
                    n_out_valid = 1'b1;
                    n_glyph     = '0;
                    n_line_end  = 1'b1;
                    n_pos       = r_pos - r_brk;
                    n_idx       = '0;
                    ram_re      = 1'b1;
                    ram_raddr   = r_brk + ONE;
                end
            end
            OP_COPY: begin
                // Move the text after the break to the front, one character a cycle.
                // The slot at the new fill position is written by the next word.
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = ram_rdata;
                cond_true = ((r_idx + ONE) == r_pos);
                if (!cond_true) begin
                    n_idx     = r_idx + ONE;
                    ram_re    = 1'b1;
                    ram_raddr = copy_src;
                end
            end
            default: begin
            end
        endcase

        if (hold) begin
            n_step = r_step;
        end else if (cond_true) begin
            n_step = uw.nxt_t;
        end else begin
            n_step = uw.nxt_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_IDLE;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_brk      <= n_brk;
        r_char     <= n_char;
        r_glyph    <= n_glyph;
        r_line_end <= n_line_end;
    end

    // The fill position never passes the last slot of the line store.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= LAST_SLOT)
        else $error("fill position beyond the line store");

    // The emit loop stays within the closed line, which never includes the last slot.
    a_emit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == STEP_EMIT) |-> ((r_idx <= r_brk) && (r_brk < LAST_SLOT)))
        else $error("emit index outside the closed line");

    // The move to the front writes only below the new fill position.
    a_copy_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == STEP_COPY) |-> (r_idx < r_pos))
        else $error("copy writes at or past the fill position");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for word_wrap_line_buffer: a directed table, then random text.
// Depends on wwlb_pkg (src/wwlb_pkg.sv) and the word_wrap_line_buffer RTL.
`timescale 1ns / 1ps

module tb_top;
    import wwlb_pkg::*;

    // Line geometry; it must match the parameter of the instance below.
    localparam int LINE_LEN = LINE_CHARS_DEF;
    localparam int NSLOTS   = LINE_LEN + 1;

    // Expected word counts typed into the directed table.
    // RES_PREDICT means the row is checked against the predictor only.
    localparam int RES_PREDICT   = -1;
    localparam int RES_NONE      = 0;
    localparam int RES_LEND_ONLY = 1;

    localparam logic [7:0] NEWLINE_CODE = 8'h0A;

    localparam int DIR_ROWS     = 25;
    localparam int RAND_CHARS   = 255;
    localparam int SETTLE_CYCLES = 2 * LINE_LEN + 20;

    // Slowest correct run: about 280 characters, each closing a line of 22 words,
    // every word held up by the longest stall, plus the sender gap and the search.
    // The limit leaves a wide margin over that.
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [7:0] glyph;
        logic       line_end;
    } t_glyph_word;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_char_in;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_glyph;
    logic       o_line_end;

    word_wrap_line_buffer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_char_in   (i_char_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_glyph     (o_glyph),
        .o_line_end  (o_line_end)
    );

    // Directed table. The opening rows hit the byte extremes on an empty line.
    // The next 21 rows fill a line with no space past the first slot, so the
    // full-line character finds no break and is carried to the next line.
    // The last row is a control code that closes that carried-over line.
    logic [7:0] dir_chars [DIR_ROWS] = '{
        8'h00, 8'hFF, 8'h20, 8'h7F,
        8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6A, 8'h6B,
        8'h6C, 8'h6D, 8'h6E, 8'h6F, 8'h70, 8'h71, 8'h72, 8'h73, 8'h74,
        8'h7E, 8'h1F
    };
    int dir_typed [DIR_ROWS] = '{
        RES_LEND_ONLY, RES_LEND_ONLY, RES_NONE, RES_NONE,
        RES_NONE, RES_NONE, RES_NONE, RES_NONE, RES_NONE, RES_NONE, RES_NONE,
        RES_NONE, RES_NONE, RES_NONE, RES_NONE, RES_NONE, RES_NONE, RES_NONE,
        RES_NONE, RES_NONE, RES_NONE, RES_NONE, RES_NONE,
        RES_PREDICT, RES_PREDICT
    };

    // Predictor state: a private copy of the line and its fill point.
    logic [7:0] text_slots [NSLOTS];
    int         fill_pt;

    // Words the block still owes, oldest first.
    t_glyph_word pending_glyphs [$];

    int  errors;
    int  chars_sent;
    int  glyphs_seen;
    int  lines_seen;
    int  cycle_cnt;

    // Handshake flags, sampled at the falling edge so that the rising edge that
    // follows can read them without racing the block's own updates.
    bit  in_take;
    bit  out_take;
    bit  in_quiet;
    bit  out_quiet;

    initial begin
        for (int k = 0; k < NSLOTS; k++) text_slots[k] = 8'h00;
        fill_pt     = 0;
        errors      = 0;
        chars_sent  = 0;
        glyphs_seen = 0;
        lines_seen  = 0;
        cycle_cnt   = 0;
        in_take     = 1'b0;
        out_take    = 1'b0;
        in_quiet    = 1'b0;
        out_quiet   = 1'b0;
    end

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("tb_top: mismatch at cycle %0d: %s", cycle_cnt, msg);
        errors++;
    endtask

    function automatic bit is_glyph(input logic [7:0] c);
        return (c >= SPACE_CODE) && !c[7];
    endfunction

    function automatic bit is_gap(input logic [7:0] c);
        return (c <= SPACE_CODE) || c[7];
    endfunction

    // Folds one character into the line and queues the words it releases.
    // Returns how many words were queued.
    function automatic int wrap_char(input logic [7:0] c);
        int pos;
        int cut;
        int produced;
        int i;
        t_glyph_word w;
        pos      = fill_pt;
        produced = 0;
        text_slots[pos] = c;
        if (is_glyph(c) && pos < LINE_LEN) begin
            fill_pt = pos + 1;
            return 0;
        end
        // Look back for a space or control code; slot 0 never counts as a break.
        cut = pos;
        while (cut > 0 && !is_gap(text_slots[cut])) cut--;
        if (cut == 0) cut = pos;
        // A break in the last slot ends the line one slot early. A space there
        // is dropped, anything else opens the next line.
        if (cut == LINE_LEN) begin
            cut--;
            if (text_slots[LINE_LEN] == SPACE_CODE) pos--;
        end
        for (i = 0; i <= cut; i++) begin
            if (is_glyph(text_slots[i])) begin
                w.glyph    = text_slots[i];
                w.line_end = 1'b0;
                pending_glyphs.push_back(w);
                produced++;
            end
        end
        w.glyph    = 8'h00;
        w.line_end = 1'b1;
        pending_glyphs.push_back(w);
        produced++;
        // Move the rest of the text to the front.
        pos -= cut;
        for (i = 0; i <= pos; i++) begin
            text_slots[i] = (cut + 1 + i < NSLOTS) ? text_slots[cut + 1 + i] : 8'h00;
        end
        fill_pt = pos;
        return produced;
    endfunction

    // Falling-edge monitor: notes both handshakes and checks each output word
    // against the oldest expectation.
    always @(negedge i_clk) begin
        t_glyph_word w;
        in_take  = i_rst_n && i_in_valid && (o_in_ready === 1'b1);
        out_take = i_rst_n && i_out_ready && (o_out_valid === 1'b1);
        if (out_take) begin
            if (pending_glyphs.size() == 0) begin
                report_mismatch($sformatf("unexpected word glyph=%h line_end=%b",
                                          o_glyph, o_line_end));
            end else begin
                w = pending_glyphs.pop_front();
                if (o_glyph !== w.glyph)
                    report_mismatch($sformatf("glyph %h, expected %h", o_glyph, w.glyph));
                if (o_line_end !== w.line_end)
                    report_mismatch($sformatf("line_end %b, expected %b",
                                              o_line_end, w.line_end));
                if (w.line_end) lines_seen++;
                else glyphs_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb_top: timeout after %0d cycles", cycle_cnt);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Receiver: draws a stall before every word, with stretches of none.
    initial begin : out_side
        int stall;
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = out_quiet ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!out_take) @(posedge i_clk);
            if ($urandom_range(0, 29) == 0) out_quiet = !out_quiet;
        end
    end

    // Sends one character after a random gap. It is entered at a rising edge
    // and returns at the edge where the character was taken, with valid still
    // high, so back-to-back words keep valid up without a glitch.
    task automatic send_char(input logic [7:0] c, input int typed);
        int gap;
        int made;
        gap = in_quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_char_in  <= c;
        @(posedge i_clk);
        while (!in_take) @(posedge i_clk);
        made = wrap_char(c);
        chars_sent++;
        if (typed != RES_PREDICT && made != typed)
            report_mismatch($sformatf("char %h released %0d words, table says %0d",
                                      c, made, typed));
        if ($urandom_range(0, 29) == 0) in_quiet = !in_quiet;
    endtask

    // A word of printable characters followed by one space.
    task automatic send_word(input int len);
        logic [7:0] c;
        repeat (len) begin
            c = 8'($urandom_range(33, 127));
            send_char(c, RES_PREDICT);
        end
        send_char(SPACE_CODE, RES_PREDICT);
    endtask

    // Holds the sender back until the block has delivered every owed word.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_glyphs.size() != 0) @(posedge i_clk);
    endtask

    initial begin : in_side
        int kind;
        bit mid_drained;
        logic [7:0] c;
        mid_drained = 1'b0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_char_in  <= 8'h00;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) send_char(dir_chars[r], dir_typed[r]);
        wait_drained();

        // Random text: mostly words and spaces so that lines really fill and
        // wrap, some words too long for a line, and some control codes and
        // raw bytes as noise.
        while (chars_sent < DIR_ROWS + RAND_CHARS) begin
            kind = $urandom_range(0, 99);
            if (kind < 62) begin
                send_word($urandom_range(1, 9));
            end else if (kind < 72) begin
                send_word($urandom_range(LINE_LEN - 3, LINE_LEN + 8));
            end else if (kind < 78) begin
                send_char(NEWLINE_CODE, RES_PREDICT);
            end else if (kind < 88) begin
                c = $urandom_range(0, 1) ? 8'($urandom_range(0, 31))
                                         : 8'($urandom_range(128, 255));
                send_char(c, RES_PREDICT);
            end else begin
                c = 8'($urandom_range(0, 255));
                send_char(c, RES_PREDICT);
            end
            if (!mid_drained && chars_sent > DIR_ROWS + RAND_CHARS / 2) begin
                wait_drained();
                mid_drained = 1'b1;
            end
        end

        // Let the block finish, then give it time to show any stray word.
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_glyphs.size() != 0)
            report_mismatch($sformatf("%0d words never arrived", pending_glyphs.size()));

        $display("Run covered %0d characters with random gaps and stalls.", chars_sent);
        $display("Compared %0d glyphs and %0d line ends; %0d mismatches.",
                 glyphs_seen, lines_seen, errors);
        if (errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
